// ===== rtl/ams_pkg.sv =====
// Shared widths, register indexes, reset values and the sine table function of the step core.
package ams_pkg;

  // Stream payloads.
  localparam int ANGLE_W  = 16;
  localparam int TICK_W   = 16;
  localparam int IN_W     = ANGLE_W + TICK_W;
  localparam int CMD_W    = 25;
  localparam int POS_W    = 32;
  localparam int RAD_W    = 19;
  localparam int OUT_USED = CMD_W + 2 * POS_W + RAD_W;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int OUT_PAD  = OUT_W - OUT_USED;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int GAIN_W     = 24;
  localparam int SCALE_W    = 17;
  localparam int PHASE_W    = 32;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TORQUE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE     = 3'd6;

  localparam logic [GAIN_W-1:0]  RST_STIFFNESS = 24'd917504;
  localparam logic [GAIN_W-1:0]  RST_DAMPING   = 24'd262144;
  localparam logic [GAIN_W-1:0]  RST_INV_MASS  = 24'd3276800;
  localparam logic [GAIN_W-1:0]  RST_TORQUE    = 24'd131072;
  localparam logic [SCALE_W-1:0] RST_DEGREE    = 17'd1144;
  localparam logic [GAIN_W-1:0]  RST_AMPLITUDE = 24'd39322;
  localparam logic [PHASE_W-1:0] RST_PHASE     = 32'd1717987;

  // Internal datapath widths.
  localparam int TORQUE_W = 28;
  localparam int ACCEL_W  = 42;
  localparam int SIN_W    = 18;
  localparam int A_W      = 42;
  localparam int B_W      = 24;
  localparam int P_W      = A_W + B_W;
  localparam int ANG_SHIFT = 7;
  localparam int FRAC_BITS = 16;

  // Division of a rounded magnitude by one million, bit serial.
  localparam int    DIV_N_W   = 58;
  localparam int    REM_W     = 21;
  localparam longint US_PER_S = 1000000;
  localparam longint HALF_US  = 500000;

  localparam int SINE_DEPTH_DEF = 1024;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // Unsigned quotient by restoring long division, one quotient bit per step.
  function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sine of a turn fraction (Q32) in signed Q2.16, by a short Taylor series.
  // Only ever evaluated while the design is elaborated.
  function automatic logic signed [SIN_W-1:0] sine_of_turn(input logic [63:0] turn);
    logic [63:0] quad;
    logic [63:0] r;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] term;
    logic [63:0] den;
    logic signed [63:0] sum;
    quad = (turn >> 30) & 64'd3;
    r = turn & 64'h3FFF_FFFF;
    if (quad[0]) begin
      r = 64'h4000_0000 - r;
    end
    a = (r * HALF_PI_Q30 + 64'h2000_0000) >> 30;
    a2 = (a * a) >> 30;
    term = a;
    sum = $signed(a);
    for (int n = 1; n <= 5; n++) begin
      den = 64'((2 * n) * (2 * n + 1));
      term = long_div((term * a2) >> 30, den);
      if (n[0]) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    sum = (sum + 64'sd8192) >>> 14;
    return quad[1] ? -SIN_W'(sum) : SIN_W'(sum);
  endfunction

endpackage

// ===== rtl/ams_serial_mul.sv =====
// Bit-serial shift-and-add multiplier for unsigned magnitudes, one multiplier bit per cycle.
module ams_serial_mul (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ams_pkg::A_W-1:0]  a_mag,
  input  logic [ams_pkg::B_W-1:0]  b,
  output logic                     done,
  output logic [ams_pkg::P_W-1:0]  p
);
  import ams_pkg::*;

  localparam int CNT_W = $clog2(B_W + 1);

  logic [P_W-1:0]   a_sh;
  logic [B_W-1:0]   b_sh;
  logic [CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(B_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p    <= '0;
      a_sh <= P_W'(a_mag);
      b_sh <= b;
    end else if (cnt != '0) begin
      if (b_sh[0]) begin
        p <= p + a_sh;
      end
      a_sh <= a_sh << 1;
      b_sh <= b_sh >> 1;
    end
  end

endmodule

// ===== rtl/ams_serial_div.sv =====
// Restoring divider by one million, one quotient bit per cycle, most significant first.
module ams_serial_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ams_pkg::DIV_N_W-1:0] dividend,
  output logic                        done,
  output logic [ams_pkg::DIV_N_W-1:0] quotient
);
  import ams_pkg::*;

  localparam int CNT_W = $clog2(DIV_N_W + 1);
  localparam logic [REM_W-1:0] DIVISOR = REM_W'(US_PER_S);

  logic [DIV_N_W-1:0] num_sh;
  logic [REM_W-1:0]   rem;
  logic [REM_W-1:0]   rem_try;
  logic               fits;
  logic [CNT_W-1:0]   cnt;

  // The remainder stays below the divisor, so its top bit is free for the shift.
  assign rem_try = {rem[REM_W-2:0], num_sh[DIV_N_W-1]};
  assign fits    = rem_try >= DIVISOR;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= CNT_W'(DIV_N_W);
      end else if (cnt != '0) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      num_sh   <= dividend;
      quotient <= '0;
    end else if (cnt != '0) begin
      rem      <= fits ? rem_try - DIVISOR : rem_try;
      num_sh   <= num_sh << 1;
      quotient <= {quotient[DIV_N_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/admittance_model_step_core.sv =====
// Admittance model step: angle to torque, Euler step of the mass-spring-damper, sine command.
// Each accepted item runs nine bit-serial products (24-bit multiplier operand) and two
// divisions by 1e6 in turn; no new item is taken while one is in flight.
// The next item is taken once the result is in the output register, even while that
// result still waits to be taken.
// Reset (synchronous): registers to their defaults, model state and sine phase to zero.
module admittance_model_step_core #(
  parameter int SINE_TABLE_DEPTH = ams_pkg::SINE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [ams_pkg::IN_W-1:0]       s_axis_tdata,   // deflection angle, tick_us
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [ams_pkg::OUT_W-1:0]      m_axis_tdata,   // sine command, model_position,
                                                         // model_velocity, angle_rad, zero pad
  input  logic                           cfg_we,
  input  logic [ams_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ams_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import ams_pkg::*;

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_GO   = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT = 3'd2;
  localparam logic [2:0] ST_DIV_WAIT = 3'd3;
  localparam logic [2:0] ST_ROM      = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;

  localparam logic [3:0] OP_ANG = 4'd0;  // angle times radians per degree
  localparam logic [3:0] OP_TRQ = 4'd1;  // torque from angle
  localparam logic [3:0] OP_K   = 4'd2;  // spring term
  localparam logic [3:0] OP_B   = 4'd3;  // damping term
  localparam logic [3:0] OP_M   = 4'd4;  // torque over mass
  localparam logic [3:0] OP_VDT = 4'd5;  // position step
  localparam logic [3:0] OP_ADT = 4'd6;  // velocity step
  localparam logic [3:0] OP_PH  = 4'd7;  // table index from phase
  localparam logic [3:0] OP_CMD = 4'd8;  // amplitude times sine

  localparam logic signed [P_W-1:0] RAD_HI = P_W'(2 ** (RAD_W - 1) - 1);
  localparam logic signed [P_W-1:0] RAD_LO = -RAD_HI - 1;
  localparam logic signed [ACCEL_W-1:0] WORD_HI = ACCEL_W'(2 ** (POS_W - 1) - 1);
  localparam logic signed [ACCEL_W-1:0] WORD_LO = -WORD_HI - 1;

  // Configuration registers.
  logic [GAIN_W-1:0]  stiffness_over_mass;
  logic [GAIN_W-1:0]  damping_over_mass;
  logic [GAIN_W-1:0]  inverse_mass;
  logic [GAIN_W-1:0]  torque_gain;
  logic [SCALE_W-1:0] degree_scale;
  logic [GAIN_W-1:0]  sine_amplitude;
  logic [PHASE_W-1:0] phase_step;

  // Sequencer and model state.
  logic [2:0]                state;
  logic [3:0]                op;
  logic signed [POS_W-1:0]   pos;
  logic signed [POS_W-1:0]   vel;
  logic [PHASE_W-1:0]        phase;
  logic [PHASE_W-1:0]        phase_next;

  // Working values of one item.
  logic signed [ANGLE_W-1:0]  angle_in;
  logic [TICK_W-1:0]          tick;
  logic signed [RAD_W-1:0]    ang;
  logic signed [TORQUE_W-1:0] torque;
  logic signed [ACCEL_W-1:0]  accel;
  logic signed [POS_W-1:0]    nx;
  logic signed [POS_W-1:0]    nv;
  logic signed [CMD_W-1:0]    cmd;
  logic [IDX_W-1:0]           idx;
  logic signed [SIN_W-1:0]    sine_q;
  logic                       prod_neg;
  logic                       div_neg;

  // Multiplier and divider hookup.
  logic signed [A_W-1:0] mul_a;
  logic [A_W-1:0]        mul_mag;
  logic                  mul_neg;
  logic [B_W-1:0]        mul_b;
  logic                  mul_start;
  logic                  mul_done;
  logic [P_W-1:0]        mul_p;
  logic                  div_start;
  logic [DIV_N_W-1:0]    div_num;
  logic                  div_done;
  logic [DIV_N_W-1:0]    div_q;

  logic [P_W-1:0]            q7;
  logic [P_W-1:0]            q16;
  logic signed [P_W-1:0]     rs7;
  logic signed [P_W-1:0]     rs16;
  logic signed [ACCEL_W-1:0] div_s;
  logic signed [ACCEL_W-1:0] step_sum;
  logic                      out_load;

  logic signed [SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  // Sine table, fixed when the design is elaborated and read through a register.
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] TURN = (64'(k) << 32) / SINE_TABLE_DEPTH;
    localparam logic signed [SIN_W-1:0] ENTRY = sine_of_turn(TURN);
    assign sine_rom[k] = ENTRY;
  end

  function automatic logic signed [POS_W-1:0] sat_word(input logic signed [ACCEL_W-1:0] val);
    if (val > WORD_HI) begin
      return POS_W'(WORD_HI);
    end else if (val < WORD_LO) begin
      return POS_W'(WORD_LO);
    end
    return POS_W'(val);
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign phase_next    = phase + phase_step;
  assign out_load      = (state == ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_ANG: begin
        mul_a = A_W'(angle_in);
        mul_b = B_W'(degree_scale);
      end
      OP_TRQ: begin
        mul_a = A_W'(ang);
        mul_b = torque_gain;
      end
      OP_K: begin
        mul_a = A_W'(pos);
        mul_b = stiffness_over_mass;
      end
      OP_B: begin
        mul_a = A_W'(vel);
        mul_b = damping_over_mass;
      end
      OP_M: begin
        mul_a = A_W'(torque);
        mul_b = inverse_mass;
      end
      OP_VDT: begin
        mul_a = A_W'(vel);
        mul_b = B_W'(tick);
      end
      OP_ADT: begin
        mul_a = accel;
        mul_b = B_W'(tick);
      end
      OP_PH: begin
        mul_a = $signed(A_W'(phase_next));
        mul_b = B_W'(SINE_TABLE_DEPTH);
      end
      OP_CMD: begin
        mul_a = A_W'(sine_q);
        mul_b = sine_amplitude;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Every product is taken as sign and magnitude, which is also how it is rounded.
  assign mul_neg   = mul_a[A_W-1];
  assign mul_mag   = mul_neg ? A_W'(-mul_a) : A_W'(mul_a);
  assign mul_start = (state == ST_MUL_GO);

  assign q7   = (mul_p + (P_W'(1) << (ANG_SHIFT - 1))) >> ANG_SHIFT;
  assign q16  = (mul_p + (P_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rs7  = prod_neg ? -$signed(q7) : $signed(q7);
  assign rs16 = prod_neg ? -$signed(q16) : $signed(q16);

  assign div_start = (state == ST_MUL_WAIT) && mul_done && (op inside {OP_VDT, OP_ADT});
  assign div_num   = DIV_N_W'(mul_p) + DIV_N_W'(HALF_US);
  assign div_s     = div_neg ? -$signed(ACCEL_W'(div_q)) : $signed(ACCEL_W'(div_q));
  assign step_sum  = ((op == OP_VDT) ? ACCEL_W'(pos) : ACCEL_W'(vel)) + div_s;

  ams_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a_mag (mul_mag),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  ams_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_num),
    .done     (div_done),
    .quotient (div_q)
  );

  // Control, configuration and model state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      op                  <= OP_ANG;
      m_axis_tvalid       <= 1'b0;
      pos                 <= '0;
      vel                 <= '0;
      phase               <= '0;
      stiffness_over_mass <= RST_STIFFNESS;
      damping_over_mass   <= RST_DAMPING;
      inverse_mass        <= RST_INV_MASS;
      torque_gain         <= RST_TORQUE;
      degree_scale        <= RST_DEGREE;
      sine_amplitude      <= RST_AMPLITUDE;
      phase_step          <= RST_PHASE;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_STIFFNESS: stiffness_over_mass <= cfg_wdata[GAIN_W-1:0];
          REG_DAMPING:   damping_over_mass   <= cfg_wdata[GAIN_W-1:0];
          REG_INV_MASS:  inverse_mass        <= cfg_wdata[GAIN_W-1:0];
          REG_TORQUE:    torque_gain         <= cfg_wdata[GAIN_W-1:0];
          REG_DEGREE:    degree_scale        <= cfg_wdata[SCALE_W-1:0];
          REG_AMPLITUDE: sine_amplitude      <= cfg_wdata[GAIN_W-1:0];
          REG_PHASE:     phase_step          <= cfg_wdata[PHASE_W-1:0];
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            op    <= OP_ANG;
            state <= ST_MUL_GO;
          end
        end
        ST_MUL_GO: begin
          state <= ST_MUL_WAIT;
        end
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (op)
              OP_VDT, OP_ADT: state <= ST_DIV_WAIT;
              OP_PH: begin
                op    <= OP_CMD;
                state <= ST_ROM;
              end
              OP_CMD: state <= ST_OUT;
              default: begin
                op    <= op + 1'b1;
                state <= ST_MUL_GO;
              end
            endcase
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            op    <= op + 1'b1;
            state <= ST_MUL_GO;
          end
        end
        ST_ROM: begin
          state <= ST_MUL_GO;
        end
        ST_OUT: begin
          if (out_load) begin
            pos   <= nx;
            vel   <= nv;
            phase <= phase_next;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers of the item in flight.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      angle_in <= $signed(s_axis_tdata[ANGLE_W-1:0]);
      tick     <= s_axis_tdata[IN_W-1:ANGLE_W];
    end
    if (mul_start) begin
      prod_neg <= mul_neg;
    end
    if ((state == ST_MUL_WAIT) && mul_done) begin
      case (op)
        OP_ANG: begin
          if (rs7 > RAD_HI) begin
            ang <= RAD_W'(RAD_HI);
          end else if (rs7 < RAD_LO) begin
            ang <= RAD_W'(RAD_LO);
          end else begin
            ang <= RAD_W'(rs7);
          end
        end
        OP_TRQ: torque <= TORQUE_W'(-rs16);
        OP_K:   accel  <= -ACCEL_W'(rs16);
        OP_B:   accel  <= accel - ACCEL_W'(rs16);
        OP_M:   accel  <= accel + ACCEL_W'(rs16);
        OP_VDT, OP_ADT: div_neg <= prod_neg;
        OP_PH:  idx    <= mul_p[PHASE_W +: IDX_W];
        OP_CMD: cmd    <= CMD_W'(rs16);
        default: ;
      endcase
    end
    if ((state == ST_DIV_WAIT) && div_done) begin
      if (op == OP_VDT) begin
        nx <= sat_word(step_sum);
      end else begin
        nv <= sat_word(step_sum);
      end
    end
    sine_q <= sine_rom[idx];
    if (out_load) begin
      m_axis_tdata <= {OUT_PAD'(1'b0), ang, nv, nx, cmd};
    end
  end

  a_mul_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_MUL_WAIT))
    else $error("multiplier finished while the sequencer was not waiting for it");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV_WAIT))
    else $error("divider finished while the sequencer was not waiting for it");

  a_result_posted: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (m_axis_tvalid && (state == ST_IDLE)))
    else $error("finished item did not reach the output register");

endmodule
